// ===== src/nhg_pkg.sv =====
package nhg_pkg;

    // Operation codes carried in the opcode field of an input item.
    typedef enum logic [1:0] {
        OP_HIT   = 2'd0,
        OP_TICK  = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_PASS = 2'd1,
        S_DONE = 2'd2
    } t_state;

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_SPEED   = 2'd0;
    localparam logic [1:0] CFG_HUE_REF = 2'd1;
    localparam logic [1:0] CFG_SAT_REF = 2'd2;
    localparam logic [1:0] CFG_VAL_REF = 2'd3;

    // Grid coordinates are compared at this width, wide enough for a column
    // index plus one on the largest grid.
    localparam int COORD_W = 6;
    typedef logic [COORD_W-1:0] t_coord;

    localparam logic [7:0] SPREAD_HEAT = 8'd16;
    localparam logic [5:0] MIN_HIT_INC = 6'd16;

    localparam logic [7:0] HUE_OFFSET [16] = '{
        8'd0, 8'd85, 8'd170, 8'd43, 8'd213, 8'd128, 8'd28, 8'd248,
        8'd60, 8'd192, 8'd11, 8'd126, 8'd36, 8'd147, 8'd241, 8'd6
    };

    typedef struct packed {
        t_op        opcode;
        logic [6:0] note;
        logic [6:0] velocity;
        logic [3:0] channel;
        logic [2:0] read_row;
        logic [3:0] read_col;
    } t_in_item;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
        logic [7:0] heat;
        logic [3:0] cell_channel;
    } t_out_item;

    // Contents of one grid cell.
    typedef struct packed {
        logic [7:0] heat;
        logic [3:0] ch;
    } t_entry;

    // Control handed from the sequencer to the update unit at the ring head.
    typedef struct packed {
        t_op        op;
        logic       hit_ok;
        t_coord     hit_row;
        t_coord     hit_col;
        logic [3:0] hit_ch;
        logic [5:0] inc;
        logic [2:0] step;
        t_coord     row;
        t_coord     col;
    } t_head_ctl;

endpackage

// ===== src/note_heatmap_hue_grid_top.sv =====
// Note heat map over a grid of GRID_ROWS x GRID_COLS cells. Every cell holds an
// 8-bit heat and a 4-bit channel, kept in a ring of identical cells that rotates
// by one place per clock while an operation runs; a single update unit at the
// head of the ring edits each entry as it passes. A note hit and a decay pass
// hold off the input until one full rotation has run, so no further item is
// taken before that rotation ends; a cell read then holds the input while it
// loads its result. A tick that does not reach the decay delay and a grid
// clear do not hold off the input. The input side is stalled while a rotation
// runs; one result register sits on the output, so a read result may wait
// there while further items are taken in. A read that finds the result
// register still occupied holds in its final state until that result has
// been transferred. Reset and the clear operation zero all cells at once.
// Configuration writes are only to be issued while the block is idle.
module note_heatmap_hue_grid_top #(
    parameter int GRID_ROWS = 5,
    parameter int GRID_COLS = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  nhg_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output nhg_pkg::t_out_item o_out_data,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [7:0]        i_cfg_data
);
    import nhg_pkg::*;

    localparam int CELLS = GRID_ROWS * GRID_COLS;
    localparam int RW    = $clog2(GRID_ROWS);
    localparam int CWD   = $clog2(GRID_COLS);

    // Control state.
    t_state         r_state, n_state;
    logic [5:0]     r_ms, n_ms;
    logic           r_out_valid, n_out_valid;
    logic [RW-1:0]  r_row, n_row;
    logic [CWD-1:0] r_col, n_col;
    logic [7:0]     r_speed, r_hue_ref, r_sat_ref, r_val_ref;

    // Operation payload, held for the length of a rotation.
    t_op        r_op, n_op;
    logic       r_hit_ok, n_hit_ok;
    logic [2:0] r_hit_row, n_hit_row;
    logic [3:0] r_hit_col, n_hit_col;
    logic [3:0] r_hit_ch, n_hit_ch;
    logic [5:0] r_inc, n_inc;
    logic [2:0] r_rd_row, n_rd_row;
    logic [3:0] r_rd_col, n_rd_col;
    t_entry     r_cap, n_cap;
    t_out_item  r_out, n_out;

    logic      w_in_acc;
    logic      w_clear;
    logic      w_shift;
    logic      w_last;
    t_entry    w_ent [CELLS];
    t_entry    w_head_out;
    t_head_ctl w_ctl;

    // Decay timing from the speed register. The divisions by 255 use the
    // identity x / 255 = (x + (x >> 8) + 1) >> 8, exact for any x up to 65534.
    logic [13:0] w_dly_x;
    logic [14:0] w_dly_s;
    logic [6:0]  w_dly_q;
    logic [5:0]  w_delay;
    logic [9:0]  w_stp_x;
    logic [10:0] w_stp_s;
    logic [2:0]  w_step;
    logic [5:0]  w_ms_inc;

    assign w_dly_x = 14'(r_speed) * 14'd40;
    assign w_dly_s = 15'(w_dly_x) + 15'(w_dly_x >> 8) + 15'd1;
    assign w_dly_q = w_dly_s[14:8];
    assign w_delay = 6'(7'd50 - w_dly_q);
    assign w_stp_x = {r_speed, 2'b00};
    assign w_stp_s = 11'(w_stp_x) + 11'(w_stp_x >> 8) + 11'd1;
    assign w_step  = 3'(w_stp_s[10:8] + 3'd1);
    assign w_ms_inc = (r_ms == 6'd63) ? r_ms : 6'(r_ms + 6'd1);

    // Hit geometry. The note is divided by twelve with the reciprocal 171/2048,
    // exact over the whole 7-bit range; the octave is then folded modulo five.
    logic [14:0] w_n_mul;
    logic [3:0]  w_oct;
    logic [6:0]  w_oct12;
    logic [6:0]  w_semi;
    logic [2:0]  w_row5;
    // The hit increment velocity * 32 / 127 is velocity / 4 or one more.
    logic [4:0]  w_q0;
    logic [5:0]  w_q1;
    logic [12:0] w_q1x127;
    logic [11:0] w_vx32;
    logic [5:0]  w_vinc;

    assign w_n_mul  = 15'(i_in_data.note) * 15'd171;
    assign w_oct    = w_n_mul[14:11];
    assign w_oct12  = {w_oct, 3'b000} + {1'b0, w_oct, 2'b00};
    assign w_semi   = i_in_data.note - w_oct12;
    assign w_row5   = (w_oct >= 4'd10) ? 3'(w_oct - 4'd10) :
                      (w_oct >= 4'd5)  ? 3'(w_oct - 4'd5)  : w_oct[2:0];
    assign w_q0     = i_in_data.velocity[6:2];
    assign w_q1     = 6'(w_q0) + 6'd1;
    assign w_q1x127 = {w_q1, 7'd0} - 13'(w_q1);
    assign w_vx32   = {i_in_data.velocity, 5'd0};
    assign w_vinc   = (w_q1x127 <= 13'(w_vx32)) ? w_q1 : 6'(w_q0);

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_clear    = w_in_acc && (i_in_data.opcode == OP_CLEAR);
    assign w_shift    = (r_state == S_PASS);
    assign w_last     = (r_row == RW'(GRID_ROWS - 1)) && (r_col == CWD'(GRID_COLS - 1));

    // The ring: cell 0 is the head, read by the update unit, whose result
    // re-enters at the far end so that a full rotation restores the order.
    for (genvar k = 0; k < CELLS; k++) begin : g_ring
        t_entry w_feed;
        if (k == CELLS - 1) begin : g_tail
            assign w_feed = w_head_out;
        end else begin : g_mid
            assign w_feed = w_ent[k+1];
        end
        nhg_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_clear (w_clear),
            .i_ent   (w_feed),
            .o_ent   (w_ent[k])
        );
    end

    always_comb begin
        w_ctl.op      = r_op;
        w_ctl.hit_ok  = r_hit_ok;
        w_ctl.hit_row = COORD_W'(r_hit_row);
        w_ctl.hit_col = COORD_W'(r_hit_col);
        w_ctl.hit_ch  = r_hit_ch;
        w_ctl.inc     = r_inc;
        w_ctl.step    = w_step;
        w_ctl.row     = COORD_W'(r_row);
        w_ctl.col     = COORD_W'(r_col);
    end

    nhg_head_unit u_head (
        .i_ctl (w_ctl),
        .i_ent (w_ent[0]),
        .o_ent (w_head_out)
    );

    // Sequencer: next state, counters and payload.
    always_comb begin
        n_state     = r_state;
        n_ms        = r_ms;
        n_out_valid = r_out_valid && i_out_stall;
        n_row       = r_row;
        n_col       = r_col;
        n_op        = r_op;
        n_hit_ok    = r_hit_ok;
        n_hit_row   = r_hit_row;
        n_hit_col   = r_hit_col;
        n_hit_ch    = r_hit_ch;
        n_inc       = r_inc;
        n_rd_row    = r_rd_row;
        n_rd_col    = r_rd_col;
        n_cap       = r_cap;
        n_out       = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_row = '0;
                    n_col = '0;
                    unique case (i_in_data.opcode)
                        OP_HIT: begin
                            n_op      = OP_HIT;
                            n_hit_row = w_row5;
                            n_hit_col = 4'(w_semi[3:0] + 4'd1);
                            n_hit_ok  = (32'(w_row5) < GRID_ROWS) &&
                                        (32'(w_semi[3:0]) + 1 < GRID_COLS);
                            n_hit_ch  = i_in_data.channel;
                            n_inc     = (w_vinc < MIN_HIT_INC) ? MIN_HIT_INC : w_vinc;
                            n_state   = S_PASS;
                        end
                        OP_TICK: begin
                            if (w_ms_inc >= w_delay) begin
                                n_ms    = '0;
                                n_op    = OP_TICK;
                                n_state = S_PASS;
                            end else begin
                                n_ms = w_ms_inc;
                            end
                        end
                        OP_READ: begin
                            n_op     = OP_READ;
                            n_rd_row = i_in_data.read_row;
                            n_rd_col = i_in_data.read_col;
                            n_cap    = '0;
                            n_state  = S_PASS;
                        end
                        OP_CLEAR: begin
                            n_ms = '0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_PASS: begin
                if (r_op == OP_READ && COORD_W'(r_row) == COORD_W'(r_rd_row) &&
                    COORD_W'(r_col) == COORD_W'(r_rd_col)) begin
                    n_cap = w_ent[0];
                end
                if (r_col == CWD'(GRID_COLS - 1)) begin
                    n_col = '0;
                    n_row = w_last ? '0 : RW'(r_row + 1'b1);
                end else begin
                    n_col = CWD'(r_col + 1'b1);
                end
                if (w_last) begin
                    n_state = (r_op == OP_READ) ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.sat          = r_sat_ref;
                    n_out.heat         = r_cap.heat;
                    n_out.cell_channel = r_cap.ch;
                    if (r_cap.heat != 8'd0) begin
                        n_out.hue = r_hue_ref + HUE_OFFSET[r_cap.ch] +
                                    (r_cap.heat[7] ? 8'hFF : {r_cap.heat[6:0], 1'b0});
                        n_out.val = r_val_ref;
                    end else begin
                        n_out.hue = r_hue_ref;
                        n_out.val = {1'b0, r_val_ref[7:1]};
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ms        <= '0;
            r_out_valid <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_speed     <= 8'd128;
            r_hue_ref   <= 8'd0;
            r_sat_ref   <= 8'd255;
            r_val_ref   <= 8'd255;
        end else begin
            r_state     <= n_state;
            r_ms        <= n_ms;
            r_out_valid <= n_out_valid;
            r_row       <= n_row;
            r_col       <= n_col;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SPEED:   r_speed   <= i_cfg_data;
                    CFG_HUE_REF: r_hue_ref <= i_cfg_data;
                    CFG_SAT_REF: r_sat_ref <= i_cfg_data;
                    CFG_VAL_REF: r_val_ref <= i_cfg_data;
                    default:     r_speed   <= r_speed;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_hit_ok  <= n_hit_ok;
        r_hit_row <= n_hit_row;
        r_hit_col <= n_hit_col;
        r_hit_ch  <= n_hit_ch;
        r_inc     <= n_inc;
        r_rd_row  <= n_rd_row;
        r_rd_col  <= n_rd_col;
        r_cap     <= n_cap;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The position counters rest at the first cell outside a rotation, so the
    // next rotation starts aligned with the ring.
    a_pos_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_PASS |-> r_row == '0 && r_col == '0)
        else $error("ring position counters not at home while idle");

    // Only a read ends in the result-loading state.
    a_done_is_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |-> r_op == OP_READ)
        else $error("result state entered by an operation other than a read");

    // A clear empties the head cell and resets the decay counter by the next cycle.
    a_clear_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in_data.opcode == OP_CLEAR |=> w_ent[0] == '0 && r_ms == '0)
        else $error("clear did not empty the grid");

    // A read result is loaded at once when the output register is free.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && !r_out_valid |=> o_out_valid && r_state == S_IDLE)
        else $error("read result not loaded into a free output register");

endmodule

// ===== src/nhg_cell.sv =====
module nhg_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  logic            i_clear,
    input  nhg_pkg::t_entry i_ent,
    output nhg_pkg::t_entry o_ent
);
    import nhg_pkg::*;

    t_entry r_ent;

    // Each cell takes its neighbour's contents whenever the ring rotates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_ent <= '0;
        end else if (i_shift) begin
            r_ent <= i_ent;
        end
    end

    assign o_ent = r_ent;

endmodule

// ===== src/nhg_head_unit.sv =====
module nhg_head_unit (
    input  nhg_pkg::t_head_ctl i_ctl,
    input  nhg_pkg::t_entry    i_ent,
    output nhg_pkg::t_entry    o_ent
);
    import nhg_pkg::*;

    logic [8:0] w_hit_sum;
    logic [8:0] w_spread_sum;
    logic [7:0] w_spread_heat;
    logic       w_center;
    logic       w_neighbour;

    assign w_hit_sum     = {1'b0, i_ent.heat} + 9'(i_ctl.inc);
    assign w_spread_sum  = {1'b0, i_ent.heat} + {1'b0, SPREAD_HEAT};
    assign w_spread_heat = w_spread_sum[8] ? 8'hFF : w_spread_sum[7:0];

    assign w_center = (i_ctl.row == i_ctl.hit_row) && (i_ctl.col == i_ctl.hit_col);
    assign w_neighbour =
        ((i_ctl.row == i_ctl.hit_row) &&
         ((COORD_W'(i_ctl.col + 1'b1) == i_ctl.hit_col) ||
          (i_ctl.col == COORD_W'(i_ctl.hit_col + 1'b1)))) ||
        ((i_ctl.col == i_ctl.hit_col) &&
         ((COORD_W'(i_ctl.row + 1'b1) == i_ctl.hit_row) ||
          (i_ctl.row == COORD_W'(i_ctl.hit_row + 1'b1))));

    always_comb begin
        o_ent = i_ent;
        unique case (i_ctl.op)
            OP_HIT: begin
                if (i_ctl.hit_ok && w_center) begin
                    o_ent.heat = w_hit_sum[8] ? 8'hFF : w_hit_sum[7:0];
                    o_ent.ch   = i_ctl.hit_ch;
                end else if (i_ctl.hit_ok && w_neighbour) begin
                    o_ent.heat = w_spread_heat;
                    // The stored channel number is compared against the new heat.
                    if (w_spread_heat > {4'd0, i_ent.ch}) begin
                        o_ent.ch = i_ctl.hit_ch;
                    end
                end
            end
            OP_TICK: begin
                if (i_ent.heat != 8'd0) begin
                    if (i_ent.heat > {5'd0, i_ctl.step}) begin
                        o_ent.heat = i_ent.heat - {5'd0, i_ctl.step};
                    end else begin
                        o_ent.heat = 8'd0;
                        o_ent.ch   = 4'd0;
                    end
                end
            end
            default: begin
                o_ent = i_ent;
            end
        endcase
    end

endmodule
